// ===== hw/rtl/rgds_pkg.sv =====
`timescale 1ns / 1ps

package rgds_pkg;

    // Image geometry limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // Field and datapath widths
    localparam int POS_W      = 13;
    localparam int CHAN_W     = 8;
    localparam int LIN_W      = 26;
    localparam int SUM_W      = 28;
    localparam int ASUM_W     = 10;
    localparam int CNT_W      = 3;
    localparam int BIT_W      = $clog2(CHAN_W);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int BIG_W      = 140;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for any x below 2^32
    localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
    localparam int          RECIP3_SHIFT = 33;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

    // Quad order: upper left, upper right, lower left, lower right
    typedef pixel_t [3:0] quad_t;

    typedef struct packed {
        logic start;
        logic ack;
    } math_req_t;

    typedef struct packed {
        logic   done;
        pixel_t px;
    } math_rsp_t;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_RD_LEFT,
        CTL_RD_RIGHT,
        CTL_LAUNCH,
        CTL_MATH
    } ctl_state_t;

    typedef enum logic [2:0] {
        M_IDLE,
        M_LIN,
        M_DIV,
        M_INV,
        M_DONE
    } math_state_t;

    typedef logic [255:0][LIN_W-1:0] gamma_lut_t;

    // Build L[v] = round(v^2.2 * 256) exactly: smallest n with (2n+1)^5 > v^11 * 2^45
    function automatic gamma_lut_t build_gamma_lut();
        gamma_lut_t       lut;
        logic [BIG_W-1:0] target;
        logic [BIG_W-1:0] pow5;
        logic [LIN_W:0]   lo;
        logic [LIN_W:0]   hi;
        logic [LIN_W:0]   mid;
        lut = '0;
        for (int v = 0; v < 256; v++) begin
            target = BIG_W'(1);
            for (int k = 0; k < 11; k++) begin
                target = target * BIG_W'(v);
            end
            target = target << 45;
            lo = '0;
            hi = (LIN_W + 1)'(1) << LIN_W;
            for (int it = 0; it <= LIN_W; it++) begin
                if (lo < hi) begin
                    mid  = lo + ((hi - lo) >> 1);
                    pow5 = BIG_W'(1);
                    for (int k = 0; k < 5; k++) begin
                        pow5 = pow5 * {{(BIG_W - LIN_W - 2){1'b0}}, mid, 1'b1};
                    end
                    if (pow5 > target) begin
                        hi = mid;
                    end else begin
                        lo = mid + (LIN_W + 1)'(1);
                    end
                end
            end
            lut[v] = lo[LIN_W-1:0];
        end
        return lut;
    endfunction

    localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

// ===== hw/rtl/rgba_gamma_downsample_2x2.sv =====
`timescale 1ns / 1ps
// m_valid rises once the request that completes its quad has passed two line store
// reads, a launch step and the linearize, divide and 8-step gamma search of the math unit.
// Throughput: one request per cycle, except a quad-completing request, which holds s_ready
// low through those steps, longer while the previous result still waits in the output register.
// Reset (aresetn, synchronous, active low) clears positions, sizes and valid state;
// the line store is not cleared, since each entry is written before it is read.
module rgba_gamma_downsample_2x2 (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rgds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgds_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_red_in,
    input  logic [7:0]                         s_green_in,
    input  logic [7:0]                         s_blue_in,
    input  logic [7:0]                         s_alpha_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_red_out,
    output logic [7:0]                         m_green_out,
    output logic [7:0]                         m_blue_out,
    output logic [7:0]                         m_alpha_out,
    output logic                               m_image_done
);

    import rgds_pkg::*;

    ctl_state_t          state_reg;
    ctl_state_t          state_next;
    logic [POS_W-1:0]    width_reg;
    logic [POS_W-1:0]    height_reg;
    logic [POS_W-1:0]    col_reg;
    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    col_next;
    logic [POS_W-1:0]    row_next;
    logic [POS_W-1:0]    col_inc;
    logic [POS_W-1:0]    row_inc;
    logic [POS_W-1:0]    out_w2;
    logic [POS_W-1:0]    out_h2;
    logic [POS_W-1:0]    cfg_width;
    logic [POS_W-1:0]    cfg_height;
    pixel_t              held_reg;
    pixel_t              ul_reg;
    pixel_t              lr_reg;
    logic [ADDR_W-2:0]   base_reg;
    logic                last_reg;
    logic                m_valid_reg;
    pixel_t              out_px_reg;
    logic                out_done_reg;

    pixel_t              in_px;
    logic                accept;
    logic                frame_active;
    logic                quad_hit;
    logic                store_wr;
    logic                hold_wr;
    logic                out_free;
    logic                load_out;
    logic                ram_en;
    logic [ADDR_W-1:0]   ram_addr;
    logic [31:0]         ram_rdata;
    quad_t               quad;
    math_req_t           req;
    math_rsp_t           rsp;

    assign in_px.red   = s_red_in;
    assign in_px.green = s_green_in;
    assign in_px.blue  = s_blue_in;
    assign in_px.alpha = s_alpha_in;

    assign s_ready      = (state_reg == CTL_IDLE);
    assign accept       = s_valid && s_ready;
    assign frame_active = (width_reg != '0) && (height_reg != '0);
    assign out_w2       = {width_reg[POS_W-1:1], 1'b0};
    assign out_h2       = {height_reg[POS_W-1:1], 1'b0};
    assign quad_hit     = frame_active && row_reg[0] && col_reg[0]
                       && (col_reg < out_w2) && (row_reg < out_h2);
    assign store_wr     = accept && frame_active && !row_reg[0];
    assign hold_wr      = accept && frame_active && row_reg[0] && !col_reg[0];
    assign out_free     = !m_valid_reg || m_ready;
    assign load_out     = (state_reg == CTL_MATH) && rsp.done && out_free;

    // Saturate register writes to the store size
    assign cfg_width  = (cfg_wdata > POS_W'(MAX_WIDTH))  ? POS_W'(MAX_WIDTH)  : cfg_wdata;
    assign cfg_height = (cfg_wdata > POS_W'(MAX_HEIGHT)) ? POS_W'(MAX_HEIGHT) : cfg_wdata;

    // Advance column and row, wrapping at the image edges
    always_comb begin
        col_inc = col_reg + POS_W'(1);
        row_inc = row_reg + POS_W'(1);
        if (!frame_active) begin
            col_next = '0;
            row_next = '0;
        end else if (col_inc >= width_reg) begin
            col_next = '0;
            row_next = (row_inc >= height_reg) ? '0 : row_inc;
        end else begin
            col_next = col_inc;
            row_next = row_reg;
        end
    end

    // Control state, positions, sizes and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTL_IDLE;
            width_reg   <= '0;
            height_reg  <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_width;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_height;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold quad pixels and the output payload
    always_ff @(posedge aclk) begin
        if (hold_wr) begin
            held_reg <= in_px;
        end
        if (accept && quad_hit) begin
            lr_reg   <= in_px;
            base_reg <= col_reg[ADDR_W-1:1];
            last_reg <= (col_reg == out_w2 - POS_W'(1)) && (row_reg == out_h2 - POS_W'(1));
        end
        if (state_reg == CTL_RD_RIGHT) begin
            ul_reg <= ram_rdata;
        end
        if (load_out) begin
            out_px_reg   <= rsp.px;
            out_done_reg <= last_reg;
        end
    end

    // Sequence the line store reads and the quad math
    always_comb begin
        state_next = state_reg;
        ram_en     = 1'b0;
        ram_addr   = col_reg[ADDR_W-1:0];
        req.start  = 1'b0;
        req.ack    = 1'b0;
        unique case (state_reg)
            CTL_IDLE: begin
                ram_en = store_wr;
                if (accept && quad_hit) begin
                    state_next = CTL_RD_LEFT;
                end
            end
            CTL_RD_LEFT: begin
                ram_en     = 1'b1;
                ram_addr   = {base_reg, 1'b0};
                state_next = CTL_RD_RIGHT;
            end
            CTL_RD_RIGHT: begin
                ram_en     = 1'b1;
                ram_addr   = {base_reg, 1'b1};
                state_next = CTL_LAUNCH;
            end
            CTL_LAUNCH: begin
                req.start  = 1'b1;
                state_next = CTL_MATH;
            end
            CTL_MATH: begin
                req.ack = load_out;
                if (load_out) begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    assign quad[0] = ul_reg;
    assign quad[1] = ram_rdata;
    assign quad[2] = held_reg;
    assign quad[3] = lr_reg;

    rgds_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (store_wr),
        .addr  (ram_addr),
        .wdata (in_px),
        .rdata (ram_rdata)
    );

    rgds_quad_math u_quad_math (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .quad    (quad),
        .rsp     (rsp)
    );

    assign m_valid      = m_valid_reg;
    assign m_red_out    = out_px_reg.red;
    assign m_green_out  = out_px_reg.green;
    assign m_blue_out   = out_px_reg.blue;
    assign m_alpha_out  = out_px_reg.alpha;
    assign m_image_done = out_done_reg;

endmodule

// ===== hw/rtl/rgds_ram.sv =====
`timescale 1ns / 1ps

module rgds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read one entry per cycle, read data registered
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                store_reg[addr] <= wdata;
            end else begin
                rdata_reg <= store_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rgds_quad_math.sv =====
`timescale 1ns / 1ps

module rgds_quad_math (
    input  logic                aclk,
    input  logic                aresetn,
    input  rgds_pkg::math_req_t req,
    input  rgds_pkg::quad_t     quad,
    output rgds_pkg::math_rsp_t rsp
);

    import rgds_pkg::*;

    math_state_t             state_reg;
    math_state_t             state_next;
    quad_t                   quad_reg;
    logic [SUM_W-1:0]        sum_reg [3];
    logic [SUM_W-1:0]        avg_reg [3];
    logic [CHAN_W-1:0]       gam_reg [3];
    logic [CNT_W-1:0]        count_reg;
    logic [CHAN_W-1:0]       alpha_reg;
    logic [BIT_W-1:0]        bit_reg;

    logic [SUM_W-1:0]        sum_lin [3];
    logic [CNT_W-1:0]        count_lin;
    logic [ASUM_W-1:0]       asum_lin;
    logic [SUM_W+31:0]       prod [3];
    logic [SUM_W-1:0]        avg_div [3];
    logic [CHAN_W-1:0]       trial [3];
    logic [CHAN_W-1:0]       gam_inv [3];

    // Linearize and sum the colour of the quad pixels with nonzero alpha
    always_comb begin
        count_lin = '0;
        asum_lin  = '0;
        for (int c = 0; c < 3; c++) begin
            sum_lin[c] = '0;
        end
        for (int i = 0; i < 4; i++) begin
            asum_lin = asum_lin + ASUM_W'(quad_reg[i].alpha);
            if (quad_reg[i].alpha != '0) begin
                count_lin = count_lin + CNT_W'(1);
                for (int c = 0; c < 3; c++) begin
                    sum_lin[c] = sum_lin[c]
                               + SUM_W'(GAMMA_LUT[quad_reg[i][CHAN_W*c +: CHAN_W]]);
                end
            end
        end
    end

    // Divide each sum by the pixel count, truncating
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod[c] = (SUM_W + 32)'(sum_reg[c]) * (SUM_W + 32)'(RECIP3);
            case (count_reg)
                CNT_W'(1): avg_div[c] = sum_reg[c];
                CNT_W'(2): avg_div[c] = sum_reg[c] >> 1;
                CNT_W'(3): avg_div[c] = SUM_W'(prod[c] >> RECIP3_SHIFT);
                CNT_W'(4): avg_div[c] = sum_reg[c] >> 2;
                default:   avg_div[c] = '0;
            endcase
        end
    end

    // Find the largest code whose linear value fits, one bit per cycle
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            trial[c] = gam_reg[c] | (CHAN_W'(1) << bit_reg);
            if (SUM_W'(GAMMA_LUT[trial[c]]) <= avg_reg[c]) begin
                gam_inv[c] = trial[c];
            end else begin
                gam_inv[c] = gam_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance the datapath registers of the current step
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    quad_reg <= quad;
                end
            end
            M_LIN: begin
                for (int c = 0; c < 3; c++) begin
                    sum_reg[c] <= sum_lin[c];
                end
                count_reg <= count_lin;
                alpha_reg <= asum_lin[ASUM_W-1:2];
            end
            M_DIV: begin
                for (int c = 0; c < 3; c++) begin
                    avg_reg[c] <= avg_div[c];
                    gam_reg[c] <= '0;
                end
                bit_reg <= BIT_W'(CHAN_W - 1);
            end
            M_INV: begin
                for (int c = 0; c < 3; c++) begin
                    gam_reg[c] <= gam_inv[c];
                end
                bit_reg <= bit_reg - BIT_W'(1);
            end
            M_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    state_next = M_LIN;
                end
            end
            M_LIN:  state_next = M_DIV;
            M_DIV:  state_next = M_INV;
            M_INV: begin
                if (bit_reg == '0) begin
                    state_next = M_DONE;
                end
            end
            M_DONE: begin
                if (req.ack) begin
                    state_next = M_IDLE;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    assign rsp.done     = (state_reg == M_DONE);
    assign rsp.px.alpha = alpha_reg;
    assign rsp.px.blue  = gam_reg[2];
    assign rsp.px.green = gam_reg[1];
    assign rsp.px.red   = gam_reg[0];

endmodule

// ===== hw/rtl/rgds_checker.sv =====
`timescale 1ns / 1ps

module rgds_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_red_out,
    input logic [7:0] m_green_out,
    input logic [7:0] m_blue_out,
    input logic [7:0] m_alpha_out,
    input logic       m_image_done
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red_out) && $stable(m_green_out)
            && $stable(m_blue_out) && $stable(m_alpha_out) && $stable(m_image_done))
        else $error("stalled result changed");

    // Drop ready only after a request was taken
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("ready dropped without a request");

    // Keep the input blocked after ready falls, while a quad is computed
    a_busy_span: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |=> !s_ready)
        else $error("quad computation ended too early");

    // Raise a new result only at the end of a quad computation
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !$past(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a quad computation");

endmodule

bind rgba_gamma_downsample_2x2 rgds_checker u_rgds_checker (.*);
